/* rtl/positional_list_engine_defines.svh */
// Assertion macros for the positional list engine checker.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ple_pkg.sv */
// Shared constants for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  localparam int CMD_W     = 3;
  localparam int POS_W     = 8;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

/* rtl/ple_ram.sv */
// Simple dual-port entry memory with a registered read port.
`timescale 1ns / 1ps

module ple_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/positional_list_engine.sv */
// Top level of the positional list engine: command sequencer around the entry memory.
//
// Commands enter on the s_ stream, one beat per command; results leave on the
// m_ stream, one beat per result, with m_tlast on the final result of each
// command. The list lives in a memory with a registered read port, so an
// insert or a delete moves the trailing entries one at a time through read
// and write cycles of that memory.
// An insert or a delete passes through a read state and a write state for
// each moved entry; every command but a dump ends with a single response
// beat, and a dump reads each entry and sends one output beat for it.
// s_tready is high only while the sequencer is idle; a command is taken even
// while a result beat still waits on m_. A stalled m_ side holds its beat and
// the sequencer waits before loading the next one.
// A synchronous reset empties the list and drops any pending beat; the entry
// memory itself is not cleared, since only entries below the count are read.
`timescale 1ns / 1ps

module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // s_tdata from bit 0: cmd[2:0], position[10:3], value[42:11], zero fill.
  input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // m_tdata from bit 0: status[1:0], entry_count[6:2], element[38:7], zero fill.
  output logic [ple_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                         m_tlast
);

  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_WR  = 3'd2;
  localparam logic [2:0] S_DEL_RD  = 3'd3;
  localparam logic [2:0] S_DEL_WR  = 3'd4;
  localparam logic [2:0] S_DMP_RD  = 3'd5;
  localparam logic [2:0] S_DMP_OUT = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       ptr;
  logic [CW-1:0]       tgt;
  logic [VALUE_W-1:0]  value_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  logic [VALUE_W-1:0]  out_elem;

  logic [CMD_W-1:0]    in_cmd;
  logic [POS_W-1:0]    in_pos;
  logic [VALUE_W-1:0]  in_value;
  logic                accept;
  logic                out_free;
  logic                out_load;
  logic                full;
  logic                empty;
  logic [POS_W:0]      pos_x;
  logic [POS_W:0]      cnt_x;
  logic [CW-1:0]       cnt_dec;
  logic [CW-1:0]       ptr_dec;
  logic [CW-1:0]       ptr_inc;
  logic [CW-1:0]       pos_idx;
  logic                dec_ins;
  logic                dec_del;
  logic                dec_dump;
  logic [CW-1:0]       dec_tgt;
  logic [STATUS_W-1:0] dec_status;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;

  assign in_cmd   = s_tdata[CMD_W-1:0];
  assign in_pos   = s_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_value = s_tdata[CMD_W+POS_W+VALUE_W-1:CMD_W+POS_W];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state == S_DMP_OUT || state == S_RESP);

  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign pos_x   = {1'b0, in_pos};
  assign cnt_x   = (POS_W + 1)'(count);
  assign cnt_dec = count - CW'(1);
  assign ptr_dec = ptr - CW'(1);
  assign ptr_inc = ptr + CW'(1);
  assign pos_idx = CW'(in_pos - POS_W'(1));

  always_comb begin
    dec_ins    = 1'b0;
    dec_del    = 1'b0;
    dec_dump   = 1'b0;
    dec_tgt    = '0;
    dec_status = ST_OK;
    case (in_cmd)
      CMD_INS_FRONT: begin
        if (full) dec_status = ST_FULL;
        else dec_ins = 1'b1;
      end
      CMD_INS_BACK: begin
        dec_tgt = count;
        if (full) dec_status = ST_FULL;
        else dec_ins = 1'b1;
      end
      CMD_DEL_FRONT: begin
        if (empty) dec_status = ST_EMPTY;
        else dec_del = 1'b1;
      end
      CMD_DEL_BACK: begin
        dec_tgt = cnt_dec;
        if (empty) dec_status = ST_EMPTY;
        else dec_del = 1'b1;
      end
      CMD_INS_AT: begin
        dec_tgt = pos_idx;
        if (full) dec_status = ST_FULL;
        else if (in_pos == '0 || pos_x > cnt_x + (POS_W + 1)'(1)) dec_status = ST_INVALID;
        else dec_ins = 1'b1;
      end
      CMD_DEL_AT: begin
        dec_tgt = pos_idx;
        if (empty) dec_status = ST_EMPTY;
        else if (in_pos == '0 || pos_x > cnt_x) dec_status = ST_INVALID;
        else dec_del = 1'b1;
      end
      CMD_DUMP: begin
        if (empty) dec_status = ST_EMPTY;
        else dec_dump = 1'b1;
      end
      default: begin
        dec_status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[AW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr[AW-1:0];
    case (state)
      S_INS_RD: begin
        if (ptr == tgt) begin
          ram_we    = 1'b1;
          ram_wdata = value_r;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_dec[AW-1:0];
        end
      end
      S_INS_WR: ram_we = 1'b1;
      S_DEL_RD: begin
        if (ptr != cnt_dec) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_inc[AW-1:0];
        end
      end
      S_DEL_WR: ram_we = 1'b1;
      S_DMP_RD: ram_re = 1'b1;
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (dec_ins) state <= S_INS_RD;
            else if (dec_del) state <= S_DEL_RD;
            else if (dec_dump) state <= S_DMP_RD;
            else state <= S_RESP;
          end
        end
        S_INS_RD: begin
          if (ptr == tgt) begin
            count <= count + CW'(1);
            state <= S_RESP;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: state <= S_INS_RD;
        S_DEL_RD: begin
          if (ptr == cnt_dec) begin
            count <= cnt_dec;
            state <= S_RESP;
          end else begin
            state <= S_DEL_WR;
          end
        end
        S_DEL_WR: state <= S_DEL_RD;
        S_DMP_RD: state <= S_DMP_OUT;
        S_DMP_OUT: begin
          if (out_free) begin
            if (ptr == cnt_dec) state <= S_IDLE;
            else state <= S_DMP_RD;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          value_r  <= in_value;
          tgt      <= dec_tgt;
          status_r <= dec_status;
          if (dec_ins) ptr <= count;
          else if (dec_del) ptr <= dec_tgt;
          else ptr <= '0;
        end
      end
      S_INS_WR: ptr <= ptr_dec;
      S_DEL_WR: ptr <= ptr_inc;
      S_DMP_OUT: begin
        if (out_free) begin
          out_status <= ST_OK;
          out_count  <= COUNT_W'(count);
          out_elem   <= ram_rdata;
          m_tlast    <= (ptr == cnt_dec);
          ptr        <= ptr_inc;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_status <= status_r;
          out_count  <= COUNT_W'(count);
          out_elem   <= '0;
          m_tlast    <= 1'b1;
        end
      end
      default: begin
        ptr <= ptr;
      end
    endcase
  end

  assign m_tdata = {1'b0, out_elem, out_count, out_status};

  ple_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (VALUE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/ple_checker.sv */
// Port-level checker for the positional list engine, bound to the top level.
`timescale 1ns / 1ps
`include "positional_list_engine_defines.svh"

module ple_checker #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ple_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast
);

  import ple_pkg::*;

  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic [VALUE_W-1:0]  element;

  assign status      = m_tdata[STATUS_W-1:0];
  assign entry_count = m_tdata[STATUS_W+COUNT_W-1:STATUS_W];
  assign element     = m_tdata[STATUS_W+COUNT_W+VALUE_W-1:STATUS_W+COUNT_W];

  `PLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "Stalled result beat changed.")
  `PLE_ASSERT_SAME(a_full_count, m_tvalid && status == ST_FULL, entry_count == COUNT_W'(CAPACITY), "Full status without a full list.")
  `PLE_ASSERT_SAME(a_empty_count, m_tvalid && status == ST_EMPTY, entry_count == '0 && element == '0, "Empty status with entries present.")
  `PLE_ASSERT_SAME(a_error_last, m_tvalid && status != ST_OK, m_tlast && element == '0, "Error result is not a single last beat.")

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
